// ----- sv/assert_macros.svh -----
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ghlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghlf_pkg
// types, codes and sizes shared by the grid localization filter
// ----------------------------------------------------------------------------
package ghlf_pkg;

  localparam int GRID_ROWS = 4;
  localparam int GRID_COLS = 5;
  localparam int NCELLS    = GRID_ROWS * GRID_COLS;
  localparam int IDX_W     = 5;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int PROB_W    = 17;
  localparam int SUM_W     = 21;
  localparam int DVD_W     = PROB_W + 16;
  localparam int CNT_W     = 6;

  localparam logic [PROB_W-1:0] ONE_Q16   = PROB_W'(65536);
  localparam logic [PROB_W-1:0] UNIFORM_P = PROB_W'(65536 / NCELLS);
  localparam logic [PROB_W-1:0] SNS_RST   = PROB_W'(45875);
  localparam logic [PROB_W-1:0] MOV_RST   = PROB_W'(52429);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_SENSE = 2'd1,
    FN_MOVE  = 2'd2,
    FN_RESET = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic {
    REG_SNS_GAIN = 1'b0,
    REG_MOV_GAIN = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    MD_DIV,
    MD_ZERO,
    MD_MOVE
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SN_RD,
    ST_SN_ACC,
    ST_DV_RD,
    ST_DV_LD,
    ST_DV_RUN,
    ST_DV_WB,
    ST_ZD_RD,
    ST_ZD_WB,
    ST_CP_RD,
    ST_CP_WR,
    ST_MV_RD,
    ST_MV_MUL,
    ST_MV_WB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] cell_index;
    logic [7:0]       map_value;
    logic [7:0]       measured_value;
    logic [1:0]       direction;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_index_res;
    logic [PROB_W-1:0] probability;
    logic              sum_zero;
    logic              last;
  } out_t;

  function automatic logic [PROB_W-1:0] sat_gain(input logic [PROB_W-1:0] g);
    sat_gain = (g > ONE_Q16) ? ONE_Q16 : g;
  endfunction

endpackage

// ----- sv/grid_histogram_localization_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_histogram_localization_filter
// histogram localization over a toroidal belief grid held in block memories
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per item: load map cell, sense, move or uniform reset.
//           sense and move keep in_stall high until the last result is taken.
//   out_* : sense and move stream one result per grid cell, index order,
//           last flags the final cell. load and reset give no results.
//   cfg_* : gain registers; write only while the block is idle (not enforced).
// sequence
//   load, reset: act on acceptance; the block stays idle.
//   sense: reads, weighs and sums every cell, then per cell runs
//          the bit-serial divider (33 steps) and writes back; a zero sum
//          instead dumps the grid unchanged, cell by cell.
//   move: copies every cell into scratch, then per cell reads two cells
//          and blends them (two scratch read ports, two multipliers).
//   the memory ports and the single divider set this sequence.
//   an out_stall holds the current result and pauses the whole walk.
// reset: gains return to defaults, belief reads as uniform through per-cell
//   valid bits, the map stays undefined until loaded.
module grid_histogram_localization_filter
  import ghlf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [PROB_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  // memories
  logic [PROB_W-1:0] bel_mem [NCELLS];
  logic [7:0]        map_mem [NCELLS];
  logic [PROB_W-1:0] scr_mem [NCELLS];

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [7:0]        meas_r, meas_nxt;
  logic              zero_r, zero_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [2*PROB_W-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [PROB_W-1:0] sns_gain_r, sns_gain_nxt, mov_gain_r, mov_gain_nxt;
  logic [NCELLS-1:0] vld_r, vld_nxt;
  logic              out_valid_r;
  out_t              out_r, out_nxt;

  logic [PROB_W-1:0] bel_q_r, scr_qa_r, scr_qb_r;
  logic              vq_r;
  logic [7:0]        map_q_r;

  logic              in_acc, out_acc, last_cell;
  logic              bel_we, scr_we, map_we;
  logic [PROB_W-1:0] bel_wd, scr_wd, bel_val, g_sns, m_mov, w_sns;
  logic [2*PROB_W-1:0] sns_prod;
  logic [PROB_W-1:0] q_sns;
  logic [IDX_W-1:0]  src_idx;
  logic [ROW_W-1:0]  sr;
  logic [COL_W-1:0]  sc;
  logic [SUM_W:0]    rem_sh;
  logic              ge;
  logic [2*PROB_W:0] mv_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && !out_stall;
  assign last_cell = (idx_r == IDX_W'(NCELLS - 1));

  // source cell of a move, cyclic on both axes
  always_comb begin
    sr = row_r;
    sc = col_r;
    case (dir_t'(dir_r))
      DIR_RIGHT: sc = (col_r == '0) ? COL_W'(GRID_COLS - 1) : col_r - 1'b1;
      DIR_LEFT:  sc = (col_r == COL_W'(GRID_COLS - 1)) ? '0 : col_r + 1'b1;
      DIR_UP:    sr = (row_r == ROW_W'(GRID_ROWS - 1)) ? '0 : row_r + 1'b1;
      default:   sr = (row_r == '0) ? ROW_W'(GRID_ROWS - 1) : row_r - 1'b1;
    endcase
    src_idx = IDX_W'(int'(sr) * GRID_COLS + int'(sc));
  end

  // arithmetic
  always_comb begin
    bel_val  = vq_r ? bel_q_r : UNIFORM_P;
    g_sns    = sat_gain(sns_gain_r);
    m_mov    = sat_gain(mov_gain_r);
    w_sns    = (map_q_r == meas_r) ? g_sns : ONE_Q16 - g_sns;
    sns_prod = bel_val * w_sns;
    q_sns    = sns_prod[PROB_W+15:16];
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    ge       = (rem_sh >= {1'b0, sum_r});
    mv_sum   = {1'b0, pa_r} + {1'b0, pb_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_t'(in_data.func) == FN_SENSE) state_nxt = ST_SN_RD;
          else if (func_t'(in_data.func) == FN_MOVE) state_nxt = ST_CP_RD;
        end
      end
      ST_SN_RD:  state_nxt = ST_SN_ACC;
      ST_SN_ACC: begin
        if (!last_cell) state_nxt = ST_SN_RD;
        else if (sum_r + SUM_W'(q_sns) == '0) state_nxt = ST_ZD_RD;
        else state_nxt = ST_DV_RD;
      end
      ST_DV_RD:  state_nxt = ST_DV_LD;
      ST_DV_LD:  state_nxt = ST_DV_RUN;
      ST_DV_RUN: if (cnt_r == CNT_W'(1)) state_nxt = ST_DV_WB;
      ST_DV_WB:  state_nxt = ST_EMIT;
      ST_ZD_RD:  state_nxt = ST_ZD_WB;
      ST_ZD_WB:  state_nxt = ST_EMIT;
      ST_CP_RD:  state_nxt = ST_CP_WR;
      ST_CP_WR:  state_nxt = last_cell ? ST_MV_RD : ST_CP_RD;
      ST_MV_RD:  state_nxt = ST_MV_MUL;
      ST_MV_MUL: state_nxt = ST_MV_WB;
      ST_MV_WB:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          if (last_cell) state_nxt = ST_IDLE;
          else if (mode_r == MD_DIV) state_nxt = ST_DV_RD;
          else if (mode_r == MD_ZERO) state_nxt = ST_ZD_RD;
          else state_nxt = ST_MV_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt     = mode_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    dir_nxt      = dir_r;
    meas_nxt     = meas_r;
    zero_nxt     = zero_r;
    sum_nxt      = sum_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    sns_gain_nxt = sns_gain_r;
    mov_gain_nxt = mov_gain_r;
    vld_nxt      = vld_r;
    out_nxt      = out_r;
    bel_we       = 1'b0;
    bel_wd       = scr_qb_r;
    scr_we       = 1'b0;
    scr_wd       = bel_val;
    map_we       = 1'b0;

    // gain registers
    if (cfg_we) begin
      if (reg_idx_t'(cfg_index) == REG_SNS_GAIN) sns_gain_nxt = cfg_data;
      else mov_gain_nxt = cfg_data;
    end

    // walk through the cells
    if (state_nxt != state_r && state_r == ST_EMIT && state_nxt != ST_IDLE
        || state_r == ST_SN_ACC && !last_cell
        || state_r == ST_CP_WR && !last_cell) begin
      idx_nxt = idx_r + 1'b1;
      if (col_r == COL_W'(GRID_COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        row_nxt = '0;
        col_nxt = '0;
        sum_nxt = '0;
        if (in_acc) begin
          dir_nxt  = in_data.direction;
          meas_nxt = in_data.measured_value;
          zero_nxt = 1'b0;
          mode_nxt = (func_t'(in_data.func) == FN_MOVE) ? MD_MOVE : MD_DIV;
          unique case (func_t'(in_data.func))
            FN_LOAD:  map_we = (in_data.cell_index < IDX_W'(NCELLS));
            FN_RESET: vld_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SN_ACC: begin
        scr_we  = 1'b1;
        scr_wd  = q_sns;
        sum_nxt = sum_r + SUM_W'(q_sns);
        if (last_cell) begin
          idx_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
          if (sum_nxt == '0) begin
            zero_nxt = 1'b1;
            mode_nxt = MD_ZERO;
          end
        end
      end
      ST_DV_LD: begin
        dvd_nxt = {scr_qb_r, 16'b0};
        rem_nxt = '0;
        cnt_nxt = CNT_W'(DVD_W);
      end
      ST_DV_RUN: begin
        rem_nxt = ge ? SUM_W'(rem_sh - {1'b0, sum_r}) : rem_sh[SUM_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      ST_DV_WB: begin
        bel_we = 1'b1;
        bel_wd = (dvd_r > DVD_W'(ONE_Q16)) ? ONE_Q16 : dvd_r[PROB_W-1:0];
        vld_nxt[idx_r] = 1'b1;
        out_nxt = '{cell_index_res: idx_r, probability: bel_wd,
                    sum_zero: zero_r, last: last_cell};
      end
      ST_ZD_WB: begin
        out_nxt = '{cell_index_res: idx_r, probability: bel_val,
                    sum_zero: zero_r, last: last_cell};
      end
      ST_CP_WR: begin
        scr_we = 1'b1;
        scr_wd = bel_val;
        if (last_cell) begin
          idx_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      ST_MV_MUL: begin
        pa_nxt = m_mov * scr_qa_r;
        pb_nxt = (ONE_Q16 - m_mov) * scr_qb_r;
      end
      ST_MV_WB: begin
        bel_we = 1'b1;
        bel_wd = mv_sum[PROB_W+15:16];
        vld_nxt[idx_r] = 1'b1;
        out_nxt = '{cell_index_res: idx_r, probability: bel_wd,
                    sum_zero: 1'b0, last: last_cell};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MD_DIV;
      idx_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      zero_r      <= 1'b0;
      sns_gain_r  <= SNS_RST;
      mov_gain_r  <= MOV_RST;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      zero_r      <= zero_nxt;
      sns_gain_r  <= sns_gain_nxt;
      mov_gain_r  <= mov_gain_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= (state_nxt == ST_EMIT);
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dir_r  <= dir_nxt;
    meas_r <= meas_nxt;
    sum_r  <= sum_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    out_r  <= out_nxt;
  end

  // belief memory, valid bit read alongside
  always_ff @(posedge clk) begin
    if (bel_we) bel_mem[idx_r] <= bel_wd;
    bel_q_r <= bel_mem[idx_r];
    vq_r    <= vld_r[idx_r];
  end

  // landmark map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[in_data.cell_index] <= in_data.map_value;
    map_q_r <= map_mem[idx_r];
  end

  // scratch memory, two read ports
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[idx_r] <= scr_wd;
    scr_qa_r <= scr_mem[src_idx];
    scr_qb_r <= scr_mem[idx_r];
  end

  // checks
  `ASSERT_IMP(a_out_busy, out_valid, in_stall, "result shown while idle")
  `ASSERT_NXT(a_one_shot, out_valid && !out_stall, !out_valid, "result repeated")
  `ASSERT_NXT(a_last_idle, out_valid && !out_stall && out_data.last, !in_stall,
              "block busy after final cell")
  `ASSERT_IMP(a_move_flag, state_r == ST_MV_WB, !zero_r, "zero flag on move")

endmodule

// ----- dv/grid_histogram_localization_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_histogram_localization_filter_tb
// drives map loads, belief resets, sense and move requests through the block
// and checks every streamed belief cell against a local fixed-point predictor
// or typed value, across several gains and under random gaps and stalls
// ----------------------------------------------------------------------------
module grid_histogram_localization_filter_tb;
  import ghlf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RAND_ITEMS     = 288;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_we;
  logic              cfg_index;
  logic [PROB_W-1:0] cfg_data;

  // predictor state
  logic [PROB_W-1:0] belief_m [NCELLS];
  logic [7:0]        lmap_m   [NCELLS];
  logic [PROB_W-1:0] sns_gain_m;
  logic [PROB_W-1:0] mov_gain_m;
  out_t              grid_q[$];

  // hand-typed values for directed rows, travel with the request
  logic              typed_on;
  logic [PROB_W-1:0] typed_p;
  logic              typed_z;

  int errors;
  int idle_mode;
  int quiet_cycles;
  int sent_rand;

  grid_histogram_localization_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // push one expected cell report per grid cell
  task automatic push_grid(input logic zf);
    out_t e;
    for (int i = 0; i < NCELLS; i++) begin
      e.cell_index_res = IDX_W'(i);
      e.probability    = typed_on ? typed_p : belief_m[i];
      e.sum_zero       = typed_on ? typed_z : zf;
      e.last           = (i == NCELLS - 1);
      grid_q.push_back(e);
    end
  endtask

  // fixed-point histogram filter step
  task automatic filter_step(input in_t d);
    longint wq [NCELLS];
    longint snap [NCELLS];
    longint g, m, sum, v;
    int sr, sc;
    case (func_t'(d.func))
      FN_LOAD: begin
        if (d.cell_index < NCELLS) lmap_m[d.cell_index] = d.map_value;
      end
      FN_RESET: begin
        for (int i = 0; i < NCELLS; i++) belief_m[i] = PROB_W'(65536 / NCELLS);
      end
      FN_SENSE: begin
        g = (sns_gain_m > 65536) ? 65536 : sns_gain_m;
        sum = 0;
        for (int i = 0; i < NCELLS; i++) begin
          wq[i] = (longint'(belief_m[i]) *
                   ((lmap_m[i] == d.measured_value) ? g : 65536 - g)) >> 16;
          sum += wq[i];
        end
        if (sum != 0) begin
          for (int i = 0; i < NCELLS; i++) begin
            v = (wq[i] << 16) / sum;
            belief_m[i] = PROB_W'((v > 65536) ? 65536 : v);
          end
        end
        push_grid(sum == 0);
      end
      default: begin
        m = (mov_gain_m > 65536) ? 65536 : mov_gain_m;
        for (int i = 0; i < NCELLS; i++) snap[i] = belief_m[i];
        for (int r = 0; r < GRID_ROWS; r++) begin
          for (int c = 0; c < GRID_COLS; c++) begin
            sr = r;
            sc = c;
            case (dir_t'(d.direction))
              DIR_RIGHT: sc = (c == 0) ? GRID_COLS - 1 : c - 1;
              DIR_LEFT:  sc = (c == GRID_COLS - 1) ? 0 : c + 1;
              DIR_UP:    sr = (r == GRID_ROWS - 1) ? 0 : r + 1;
              default:   sr = (r == 0) ? GRID_ROWS - 1 : r - 1;
            endcase
            belief_m[r*GRID_COLS+c] = PROB_W'((m * snap[sr*GRID_COLS+sc] +
                                      (65536 - m) * snap[r*GRID_COLS+c]) >> 16);
          end
        end
        push_grid(1'b0);
      end
    endcase
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (idle_mode == 0) out_stall <= ($urandom_range(99) < 79);
    else if (idle_mode == 1) out_stall <= ($urandom_range(99) < 37);
    else out_stall <= 1'b0;
  end

  // request and result monitor, scoreboard and watchdog
  always @(posedge clk) begin
    out_t e;
    logic hit;
    if (rst_n) begin
      hit = 1'b0;
      if (in_valid && !in_stall) begin
        hit = 1'b1;
        filter_step(in_data);
      end
      if (out_valid && !out_stall) begin
        hit = 1'b1;
        if (grid_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          e = grid_q.pop_front();
          if (out_data.cell_index_res !== e.cell_index_res ||
              out_data.probability !== e.probability ||
              out_data.sum_zero !== e.sum_zero || out_data.last !== e.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      if (hit) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("grid_histogram_localization_filter_tb: FAIL");
        $finish;
      end
    end
  end

  // one request, with an optional sender gap and optional typed value
  task automatic send_req(input in_t d, input logic has_typed = 1'b0,
                          input logic [PROB_W-1:0] tp = '0, input logic tz = 1'b0);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 79 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    typed_on <= has_typed;
    typed_p  <= tp;
    typed_z  <= tz;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // hold off until every expected cell has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grid_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input reg_idx_t r, input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= PROB_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == REG_SNS_GAIN) sns_gain_m = PROB_W'(v);
    else mov_gain_m = PROB_W'(v);
  endtask

  function automatic in_t mk(input func_t f, input int idx, input int mv,
                             input int meas, input dir_t dr);
    in_t d;
    d.func           = f;
    d.cell_index     = IDX_W'(idx);
    d.map_value      = 8'(mv);
    d.measured_value = 8'(meas);
    d.direction      = dr;
    return d;
  endfunction

  // mostly sense and move with real landmarks, some loads and resets
  function automatic in_t rand_req();
    in_t d;
    int k;
    d = in_t'({$urandom, $urandom});
    k = $urandom_range(99);
    if (k < 40) begin
      d.func = FN_SENSE;
      if ($urandom_range(3) != 0) d.measured_value = lmap_m[$urandom_range(NCELLS-1)];
    end else if (k < 75) d.func = FN_MOVE;
    else if (k < 92) begin
      d.func = FN_LOAD;
      if ($urandom_range(3) != 0) d.map_value = 8'($urandom_range(5));
    end else d.func = FN_RESET;
    return d;
  endfunction

  typedef struct {
    in_t               req;
    logic              has_typed;
    logic [PROB_W-1:0] tp;
    logic              tz;
  } row_t;

  row_t dir_tab[$];

  initial begin
    int unsigned gains[6][2];
    int per_phase;
    errors     = 0;
    idle_mode  = 0;
    sent_rand  = 0;
    quiet_cycles = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_SNS_GAIN;
    cfg_data  = '0;
    typed_on  = 1'b0;
    typed_p   = '0;
    typed_z   = 1'b0;
    sns_gain_m = PROB_W'(45875);
    mov_gain_m = PROB_W'(52429);
    for (int i = 0; i < NCELLS; i++) begin
      belief_m[i] = PROB_W'(65536 / NCELLS);
      lmap_m[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // map setup covers every cell so no sense reads an unwritten entry
    for (int i = 0; i < NCELLS; i++)
      send_req(mk(FN_LOAD, i, (i == NCELLS-1) ? 255 : (i == 7) ? 8'hA5 : i % 4, 0,
                  DIR_RIGHT));

    // directed table at reset gains
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_RIGHT), 1'b1, 17'd3276, 1'b0});
    dir_tab.push_back('{mk(FN_LOAD, 31, 8'hFF, 0, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_LOAD, 20, 8'h5A, 0, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 1, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_LEFT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_UP), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_DOWN), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 255, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 8'hA5, DIR_DOWN), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 8'h77, DIR_UP), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_RESET, 0, 0, 0, DIR_RIGHT), 1'b0, '0, 1'b0});
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].has_typed,
                                  dir_tab[i].tp, dir_tab[i].tz);
    drain();

    // full-trust sensor with no matching landmark gives a zero sum
    write_gain(REG_SNS_GAIN, 65536);
    write_gain(REG_MOV_GAIN, 0);
    dir_tab.delete();
    dir_tab.push_back('{mk(FN_RESET, 0, 0, 0, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 8'h77, DIR_RIGHT), 1'b1, 17'd3276, 1'b1});
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_UP), 1'b1, 17'd3276, 1'b0});
    dir_tab.push_back('{mk(FN_SENSE, 0, 0, 2, DIR_RIGHT), 1'b0, '0, 1'b0});
    dir_tab.push_back('{mk(FN_MOVE, 0, 0, 0, DIR_LEFT), 1'b0, '0, 1'b0});
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].has_typed,
                                  dir_tab[i].tp, dir_tab[i].tz);
    drain();

    // random phases across gain extremes and saturation
    gains = '{'{0, 65536}, '{131071, 131071}, '{65536, 1}, '{1, 65535},
              '{45875, 52429}, '{0, 0}};
    gains[4][0] = $urandom_range(131071);
    gains[4][1] = $urandom_range(131071);
    per_phase = RAND_ITEMS / 6 + 1;
    for (int ph = 0; ph < 6; ph++) begin
      write_gain(REG_SNS_GAIN, gains[ph][0]);
      write_gain(REG_MOV_GAIN, gains[ph][1]);
      for (int n = 0; n < per_phase; n++) begin
        idle_mode = (sent_rand < RAND_ITEMS / 3) ? 0 :
                    (sent_rand < 2 * RAND_ITEMS / 3) ? 1 : 2;
        if ($urandom_range(39) == 0) drain();
        send_req(rand_req());
        sent_rand++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("grid_histogram_localization_filter_tb: PASS");
    end else begin
      $display("grid_histogram_localization_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
